// File: src/bsm_pkg.sv
package bsm_pkg;

    // configuration port
    localparam int CFG_INDEX_BITS  = 2;
    localparam int CFG_DATA_BITS   = 11;
    localparam int WIDTH_REG_BITS  = 6;
    localparam int HEIGHT_REG_BITS = 11;

    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 2'd1;

    // factors of three in the divisor
    localparam logic [1:0] THREES_NONE = 2'd0;
    localparam logic [1:0] THREES_ONE  = 2'd1;
    localparam logic [1:0] THREES_TWO  = 2'd2;

    typedef struct packed {
        logic [1:0] twos;
        logic [1:0] threes;
        logic       last_of_run;
        logic       frame_end;
    } t_ctl;

endpackage

// File: src/bsm_if.sv
interface bsm_cfg_if;
    import bsm_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

interface bsm_pixel_if #(
    parameter int PIXEL_BITS = 8
);
    logic                  valid;
    logic                  ready;
    logic [PIXEL_BITS-1:0] pixel_in;

    modport source (output valid, output pixel_in, input ready);
    modport sink   (input valid, input pixel_in, output ready);
endinterface

interface bsm_result_if #(
    parameter int PIXEL_BITS = 8
);
    logic                  valid;
    logic                  ready;
    logic [PIXEL_BITS-1:0] smoothed_pixel;
    logic                  last_of_run;
    logic                  frame_end;

    modport source (output valid, output smoothed_pixel, output last_of_run,
                    output frame_end, input ready);
    modport sink   (input valid, input smoothed_pixel, input last_of_run,
                    input frame_end, output ready);
endinterface

// File: src/bsm_front.sv
module bsm_front #(
    parameter int MAX_WIDTH  = 32,
    parameter int MAX_HEIGHT = 1024,
    parameter int PIXEL_BITS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    bsm_cfg_if.sink               i_cfg,
    bsm_pixel_if.sink             i_pix,
    output logic                  o_push_valid,
    input  logic                  i_push_ready,
    output logic [PIXEL_BITS+3:0] o_push_sum,
    output bsm_pkg::t_ctl         o_push_ctl
);
    import bsm_pkg::*;

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int VW = PIXEL_BITS + 2;
    localparam int SW = PIXEL_BITS + 4;

    localparam logic S_RUN   = 1'b0;
    localparam logic S_FLUSH = 1'b1;

    localparam logic [1:0] BUF_A = 2'd0;
    localparam logic [1:0] BUF_B = 2'd1;
    localparam logic [1:0] BUF_C = 2'd2;

    // line buffers, roles rotate at each row end except the frame's last
    logic [PIXEL_BITS-1:0] r_buf_a [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] r_buf_b [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] r_buf_c [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] r_rd_a, r_rd_b, r_rd_c;

    logic          r_state;
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [CW-1:0] r_last_col;
    logic [RW-1:0] r_last_row;
    logic [1:0]    r_rot;

    // column slot
    logic                  r_b_valid;
    logic                  r_b_phase;
    logic [PIXEL_BITS-1:0] r_b_pix;
    logic [CW-1:0]         r_b_col;
    logic [1:0]            r_b_up_sel;
    logic [1:0]            r_b_mid_sel;
    logic                  r_b_ua;
    logic                  r_b_dn;
    logic                  r_b_emit;
    logic                  r_b_flush;
    logic                  r_b_rowend;
    logic                  r_b_frame_last;
    logic [VW-1:0]         r_v1, r_v2;

    logic [1:0]                 above_sel, mid_sel;
    logic [PIXEL_BITS-1:0]      up_val, mid_val;
    logic [VW-1:0]              v;
    logic                       has_l1, has_l2, row_two, row_three;
    logic                       need1, need2, b_done, phase_set, slot_free;
    logic                       accept, fl_issue, issue, row_end, last_row;
    logic [SW-1:0]              e1_sum, e2_sum;
    t_ctl                       e1_ctl, e2_ctl;
    logic [WIDTH_REG_BITS-1:0]  cfg_w;
    logic [HEIGHT_REG_BITS-1:0] cfg_h;

    always_comb begin
        case (r_rot)
            BUF_B:   begin above_sel = BUF_C; mid_sel = BUF_A; end
            BUF_C:   begin above_sel = BUF_A; mid_sel = BUF_B; end
            default: begin above_sel = BUF_B; mid_sel = BUF_C; end
        endcase
    end

    always_comb begin
        case (r_b_up_sel)
            BUF_B:   up_val = r_rd_b;
            BUF_C:   up_val = r_rd_c;
            default: up_val = r_rd_a;
        endcase
        case (r_b_mid_sel)
            BUF_B:   mid_val = r_rd_b;
            BUF_C:   mid_val = r_rd_c;
            default: mid_val = r_rd_a;
        endcase
    end

    // vertical sum of the slot's column, then the horizontal window
    assign v = (r_b_ua ? VW'(up_val) : '0) + VW'(mid_val) + (r_b_dn ? VW'(r_b_pix) : '0);

    assign has_l1    = (r_b_col != '0);
    assign has_l2    = (r_b_col > CW'(1));
    assign row_two   = r_b_ua ^ r_b_dn;
    assign row_three = r_b_ua & r_b_dn;

    assign e1_sum = (has_l2 ? SW'(r_v2) : '0) + SW'(r_v1) + SW'(v);
    assign e2_sum = (has_l1 ? SW'(r_v1) : '0) + SW'(v);

    always_comb begin
        e1_ctl.twos        = {1'b0, row_two} + {1'b0, !has_l2};
        e1_ctl.threes      = {1'b0, row_three} + {1'b0, has_l2};
        e1_ctl.last_of_run = !r_b_rowend && !r_b_flush;
        e1_ctl.frame_end   = 1'b0;
        e2_ctl.twos        = {1'b0, row_two} + {1'b0, has_l1};
        e2_ctl.threes      = {1'b0, row_three};
        e2_ctl.last_of_run = r_b_flush || !r_b_frame_last;
        e2_ctl.frame_end   = r_b_flush;
    end

    assign need1     = r_b_emit && has_l1 && !r_b_phase;
    assign need2     = r_b_emit && r_b_rowend;
    assign b_done    = r_b_valid && (!(need1 || need2) || (i_push_ready && !(need1 && need2)));
    assign phase_set = r_b_valid && need1 && need2 && i_push_ready;
    assign slot_free = !r_b_valid || b_done;

    assign o_push_valid = r_b_valid && (need1 || need2);
    assign o_push_sum   = need1 ? e1_sum : e2_sum;
    assign o_push_ctl   = need1 ? e1_ctl : e2_ctl;

    assign i_pix.ready = (r_state == S_RUN) && slot_free;
    assign i_cfg.ready = 1'b1;

    assign accept   = i_pix.valid && i_pix.ready;
    assign fl_issue = (r_state == S_FLUSH) && slot_free;
    assign issue    = accept || fl_issue;
    assign row_end  = (r_col == r_last_col);
    assign last_row = (r_row == r_last_row);
    assign cfg_w    = i_cfg.data[WIDTH_REG_BITS-1:0];
    assign cfg_h    = i_cfg.data[HEIGHT_REG_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (accept) begin
            case (r_rot)
                BUF_B:   r_buf_b[r_col] <= i_pix.pixel_in;
                BUF_C:   r_buf_c[r_col] <= i_pix.pixel_in;
                default: r_buf_a[r_col] <= i_pix.pixel_in;
            endcase
        end
        if (issue) begin
            r_rd_a <= r_buf_a[r_col];
            r_rd_b <= r_buf_b[r_col];
            r_rd_c <= r_buf_c[r_col];
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b_pix        <= i_pix.pixel_in;
            r_b_col        <= r_col;
            r_b_up_sel     <= above_sel;
            r_b_mid_sel    <= mid_sel;
            r_b_ua         <= (r_row > RW'(1));
            r_b_dn         <= 1'b1;
            r_b_emit       <= (r_row != '0);
            r_b_flush      <= 1'b0;
            r_b_rowend     <= row_end;
            r_b_frame_last <= row_end && last_row;
        end else if (fl_issue) begin
            r_b_pix        <= '0;
            r_b_col        <= r_col;
            r_b_up_sel     <= mid_sel;
            r_b_mid_sel    <= r_rot;
            r_b_ua         <= (r_row != '0);
            r_b_dn         <= 1'b0;
            r_b_emit       <= 1'b1;
            r_b_flush      <= 1'b1;
            r_b_rowend     <= row_end;
            r_b_frame_last <= 1'b0;
        end
        if (b_done) begin
            r_v2 <= r_v1;
            r_v1 <= v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_RUN;
            r_col      <= '0;
            r_row      <= '0;
            r_last_col <= '0;
            r_last_row <= '0;
            r_rot      <= BUF_A;
            r_b_valid  <= 1'b0;
            r_b_phase  <= 1'b0;
        end else begin
            if (issue) begin
                r_b_valid <= 1'b1;
            end else if (b_done) begin
                r_b_valid <= 1'b0;
            end
            if (issue || b_done) begin
                r_b_phase <= 1'b0;
            end else if (phase_set) begin
                r_b_phase <= 1'b1;
            end

            case (r_state)
                S_RUN: begin
                    if (accept) begin
                        if (row_end) begin
                            r_col <= '0;
                            if (last_row) begin
                                r_state <= S_FLUSH;
                            end else begin
                                r_row <= RW'(r_row + 1'b1);
                                case (r_rot)
                                    BUF_A:   r_rot <= BUF_B;
                                    BUF_B:   r_rot <= BUF_C;
                                    default: r_rot <= BUF_A;
                                endcase
                            end
                        end else begin
                            r_col <= CW'(r_col + 1'b1);
                        end
                    end
                end
                S_FLUSH: begin
                    if (fl_issue) begin
                        if (row_end) begin
                            r_col   <= '0;
                            r_row   <= '0;
                            r_state <= S_RUN;
                        end else begin
                            r_col <= CW'(r_col + 1'b1);
                        end
                    end
                end
                default: r_state <= S_RUN;
            endcase

            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    REG_IMAGE_WIDTH: begin
                        if (cfg_w == '0) begin
                            r_last_col <= '0;
                        end else if (32'(cfg_w) > MAX_WIDTH) begin
                            r_last_col <= CW'(MAX_WIDTH - 1);
                        end else begin
                            r_last_col <= CW'(cfg_w - 1'b1);
                        end
                        r_col <= '0;
                        r_row <= '0;
                    end
                    REG_IMAGE_HEIGHT: begin
                        if (cfg_h == '0) begin
                            r_last_row <= '0;
                        end else if (32'(cfg_h) > MAX_HEIGHT) begin
                            r_last_row <= RW'(MAX_HEIGHT - 1);
                        end else begin
                            r_last_row <= RW'(cfg_h - 1'b1);
                        end
                        r_col <= '0;
                        r_row <= '0;
                    end
                    default: ;
                endcase
            end
        end
    end

endmodule

// File: src/bsm_queue.sv
module bsm_queue #(
    parameter int DATA_BITS = 18,
    parameter int DEPTH     = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [DATA_BITS-1:0] i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [DATA_BITS-1:0] o_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [DATA_BITS-1:0] r_mem [DEPTH];
    logic [PW-1:0]        r_wp, r_rp;
    logic [PW:0]          r_cnt;
    logic                 push, pop;

    assign o_ready = (r_cnt != (PW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : PW'(r_wp + 1'b1);
            end
            if (pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : PW'(r_rp + 1'b1);
            end
            case ({push, pop})
                2'b10:   r_cnt <= (PW+1)'(r_cnt + 1'b1);
                2'b01:   r_cnt <= (PW+1)'(r_cnt - 1'b1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// File: src/bsm_divide.sv
module bsm_divide #(
    parameter int PIXEL_BITS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [PIXEL_BITS+3:0] i_sum,
    input  bsm_pkg::t_ctl         i_ctl,
    bsm_result_if.source          o_res
);
    import bsm_pkg::*;

    localparam int SW = PIXEL_BITS + 4;
    localparam int PW = 2 * SW;
    localparam int K3 = SW + 1;
    localparam int K9 = SW + 3;
    // rounded-up reciprocals, exact for any sum below 2**SW
    localparam logic [SW-1:0] RECIP3 = SW'(((64'd1 << K3) + 64'd2) / 64'd3);
    localparam logic [SW-1:0] RECIP9 = SW'(((64'd1 << K9) + 64'd8) / 64'd9);

    logic [SW-1:0] x;
    logic [PW-1:0] prod;
    logic [PW-1:0] r_p;
    logic [1:0]    r_p_threes;
    logic          r_p_valid, r_p_last, r_p_fend;
    logic [PW-1:0] quot;
    logic          r_o_valid;
    logic          o_free, p_free;

    assign x = i_sum >> i_ctl.twos;

    always_comb begin
        case (i_ctl.threes)
            THREES_ONE: prod = PW'(x) * PW'(RECIP3);
            THREES_TWO: prod = PW'(x) * PW'(RECIP9);
            default:    prod = PW'(x);
        endcase
    end

    always_comb begin
        case (r_p_threes)
            THREES_ONE: quot = r_p >> K3;
            THREES_TWO: quot = r_p >> K9;
            default:    quot = r_p;
        endcase
    end

    assign o_free  = !r_o_valid || o_res.ready;
    assign p_free  = !r_p_valid || o_free;
    assign o_ready = p_free;
    assign o_res.valid = r_o_valid;

    always_ff @(posedge i_clk) begin
        if (i_valid && p_free) begin
            r_p        <= prod;
            r_p_threes <= i_ctl.threes;
            r_p_last   <= i_ctl.last_of_run;
            r_p_fend   <= i_ctl.frame_end;
        end
        if (r_p_valid && o_free) begin
            o_res.smoothed_pixel <= quot[PIXEL_BITS-1:0];
            o_res.last_of_run    <= r_p_last;
            o_res.frame_end      <= r_p_fend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (p_free) begin
                r_p_valid <= i_valid;
            end
            if (o_free) begin
                r_o_valid <= r_p_valid;
            end
        end
    end

endmodule

// File: src/box_smoother_3x3_edge_aware_unit.sv
// 3x3 mean filter over a raster stream of pixels. Each result is the floor of the mean of the
// pixel's neighbourhood, counting only neighbours inside the frame, so edges and corners divide
// by 6, 4, 3, 2 or 1. Results leave in raster order one row and one pixel behind the input, and
// the frame's last pixel flushes the whole bottom row; last_of_run marks the final word caused
// by an input pixel (for the last pixel, the end of its flush) and frame_end marks the
// bottom-right result. Writing either size register restarts the frame. Mid-row the block
// takes one pixel per cycle while the queue has room; a row-end pixel yields two words, and the
// frame's last pixel adds a flush, one line-buffer read per column. The divider behind the queue
// is a two-stage reciprocal multiply delivering one word per cycle while the output is ready.
module box_smoother_3x3_edge_aware_unit #(
    parameter int MAX_WIDTH  = 32,
    parameter int MAX_HEIGHT = 1024,
    parameter int PIXEL_BITS = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bsm_cfg_if.sink       i_cfg,
    bsm_pixel_if.sink     i_pix,
    bsm_result_if.source  o_res
);
    import bsm_pkg::*;

    localparam int SW         = PIXEL_BITS + 4;
    localparam int FIFO_DEPTH = 4;
    localparam int QW         = SW + $bits(t_ctl);
    localparam logic [SW-1:0] SUM_MAX = SW'(9 * ((1 << PIXEL_BITS) - 1));

    logic          push_valid, push_ready;
    logic [SW-1:0] push_sum;
    t_ctl          push_ctl;
    logic          pop_valid, pop_ready;
    logic [QW-1:0] pop_data;
    logic [SW-1:0] pop_sum;
    t_ctl          pop_ctl;

    bsm_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (i_cfg),
        .i_pix        (i_pix),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_sum   (push_sum),
        .o_push_ctl   (push_ctl)
    );

    bsm_queue #(
        .DATA_BITS (QW),
        .DEPTH     (FIFO_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (push_valid),
        .o_ready (push_ready),
        .i_data  ({push_sum, push_ctl}),
        .o_valid (pop_valid),
        .i_ready (pop_ready),
        .o_data  (pop_data)
    );

    assign pop_sum = pop_data[QW-1 -: SW];
    assign pop_ctl = pop_data[$bits(t_ctl)-1:0];

    bsm_divide #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_divide (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (pop_valid),
        .o_ready (pop_ready),
        .i_sum   (pop_sum),
        .i_ctl   (pop_ctl),
        .o_res   (o_res)
    );

    a_frame_end_closes_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.frame_end |-> o_res.last_of_run)
        else $error("frame end word without last_of_run");

    a_divisor_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push_valid |-> ({1'b0, push_ctl.twos} + {1'b0, push_ctl.threes} <= 3'd2))
        else $error("neighbourhood divisor outside 1..9 set");

    a_sum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push_valid |-> (push_sum <= SUM_MAX))
        else $error("neighbourhood sum out of range");

endmodule
